FILE: hw/rtl/lsjt_pkg.sv
// ----------------------------------------------------------------------------
// lsjt_pkg
// Shared types, codes and constants of the line sensor junction tracker.
// ----------------------------------------------------------------------------
package lsjt_pkg;

  // field widths
  localparam int unsigned SENSOR_W   = 8;
  localparam int unsigned WEIGHT_W   = 16;
  localparam int unsigned CODE_W     = 3;
  localparam int unsigned WINLEN_W   = 4;
  localparam int unsigned HOLD_W     = 8;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned NUM_WEIGHTS = 6;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_B1     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CROSS_HOLD    = 8'd7;

  // sensor masks
  localparam logic [SENSOR_W-1:0] EDGE_MASK  = 8'h81;
  localparam logic [SENSOR_W-1:0] FRONT_MASK = 8'h3C;
  localparam logic [1:0]          SIDE_PAIR  = 2'b11;

  // reset values of the configuration registers
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET [NUM_WEIGHTS] = '{
    16'hFA24, 16'hFE0C, 16'hFF38, 16'h00C8, 16'h01F4, 16'h05DC
  };
  localparam logic [WINLEN_W-1:0] WINDOW_LENGTH_RESET = 4'd10;
  localparam logic [HOLD_W-1:0]   CROSS_HOLD_RESET    = 8'd20;

  // serial divider: quotient bits resolved per cycle
  localparam int unsigned DIV_BITS_PER_CYCLE = 2;
  localparam int unsigned DIV_CYCLES = WEIGHT_W / DIV_BITS_PER_CYCLE;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES);

  // road type, bits are left, front, right
  typedef enum logic [2:0] {
    RT_UNKNOWN  = 3'b000,
    RT_RIGHT    = 3'b001,
    RT_STRAIGHT = 3'b010,
    RT_TRIGHT   = 3'b011,
    RT_LEFT     = 3'b100,
    RT_TBOTH    = 3'b101,
    RT_TLEFT    = 3'b110,
    RT_CROSS    = 3'b111
  } road_type_e;

  // reported road codes
  typedef enum logic [CODE_W-1:0] {
    CODE_OFFSET = 3'd0,
    CODE_CROSS  = 3'd1,
    CODE_TBOTH  = 3'd2,
    CODE_TLEFT  = 3'd3,
    CODE_TRIGHT = 3'd4,
    CODE_LEFT   = 3'd5,
    CODE_RIGHT  = 3'd6
  } road_code_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH
  } ctrl_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
    logic push;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

FILE: hw/rtl/lsjt_if.sv
// ----------------------------------------------------------------------------
// lsjt_if
// Valid/ready channel interfaces for sensor readings, results and config.
// ----------------------------------------------------------------------------
interface lsjt_in_if
  import lsjt_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [SENSOR_W-1:0] raw_sensor;

  modport source (output valid, output raw_sensor, input ready);
  modport sink   (input valid, input raw_sensor, output ready);
endinterface

interface lsjt_out_if
  import lsjt_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic [CODE_W-1:0]          road_code;
  logic signed [WEIGHT_W-1:0] line_offset;

  modport source (output valid, output road_code, output line_offset, input ready);
  modport sink   (input valid, input road_code, input line_offset, output ready);
endinterface

interface lsjt_cfg_if
  import lsjt_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/lsjt_div.sv
// ----------------------------------------------------------------------------
// lsjt_div
// Serial signed divider of the weight sum by the set bit count, restoring,
// DIV_BITS_PER_CYCLE quotient bits per step, truncating toward zero.
// ----------------------------------------------------------------------------
module lsjt_div
  import lsjt_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       step_i,
  input  logic signed [WEIGHT_W-1:0] dividend_i,
  input  logic [CNT_W-1:0]           divisor_i,
  output logic signed [WEIGHT_W-1:0] quotient_o
);

  logic [WEIGHT_W-1:0] num_q, num_d;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic [CNT_W-1:0]    dvs_q, dvs_d;
  logic                neg_q, neg_d;

  // load magnitude on start, then shift quotient bits in
  always_comb begin
    logic [CNT_W-1:0]    rr;
    logic [WEIGHT_W-1:0] n;
    logic [CNT_W-1:0]    r;
    num_d = num_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    neg_d = neg_q;
    n = num_q;
    r = rem_q;
    rr = '0;
    if (start_i) begin
      neg_d = dividend_i[WEIGHT_W-1];
      num_d = dividend_i[WEIGHT_W-1] ? (~dividend_i + 1'b1) : dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (step_i) begin
      for (int k = 0; k < DIV_BITS_PER_CYCLE; k++) begin
        rr = {r[CNT_W-2:0], n[WEIGHT_W-1]};
        if (rr >= dvs_q) begin
          r = rr - dvs_q;
          n = {n[WEIGHT_W-2:0], 1'b1};
        end else begin
          r = rr;
          n = {n[WEIGHT_W-2:0], 1'b0};
        end
      end
      num_d = n;
      rem_d = r;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q <= 1'b0;
    end else begin
      neg_q <= neg_d;
    end
  end

  // sign correction
  assign quotient_o = neg_q ? (~num_q + 1'b1) : num_q;

endmodule

FILE: hw/rtl/lsjt_ctrl.sv
// ----------------------------------------------------------------------------
// lsjt_ctrl
// Sequencer: takes a reading, runs the divider, moves the result out.
// ----------------------------------------------------------------------------
module lsjt_ctrl
  import lsjt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e          state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          state_d = ST_PUSH;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_PUSH: begin
        if (status_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/lsjt_dp.sv
// ----------------------------------------------------------------------------
// lsjt_dp
// Datapath: config registers, junction window state, weight sum, divider
// and the output register.
// ----------------------------------------------------------------------------
module lsjt_dp
  import lsjt_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ctrl_cmd_t                  cmd_i,
  output dp_status_t                 status_o,
  input  logic [SENSOR_W-1:0]        raw_sensor_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [CODE_W-1:0]          road_code_o,
  output logic signed [WEIGHT_W-1:0] line_offset_o
);

  logic [WEIGHT_W-1:0] weight_q [NUM_WEIGHTS];
  logic [WINLEN_W-1:0] window_length_q;
  logic [HOLD_W-1:0]   cross_hold_q;

  logic [WINLEN_W-1:0] wc_q, wc_d;
  logic [SENSOR_W-1:0] acc_q, acc_d;
  road_type_e          rt_q, rt_d;
  logic [HOLD_W-1:0]   hc_q, hc_d;

  road_code_e          code_d, code_q;
  logic                mean_d, mean_q;
  logic [SENSOR_W-1:0] d;
  logic                front;
  logic [WEIGHT_W-1:0] sum;
  logic [CNT_W-1:0]    cnt;

  logic signed [WEIGHT_W-1:0] quotient;
  logic                       out_valid_q;
  logic [CODE_W-1:0]          out_code_q;
  logic signed [WEIGHT_W-1:0] out_offset_q;

  // config writes, always accepted
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_WEIGHTS; i++) begin
        weight_q[i] <= WEIGHT_RESET[i];
      end
      window_length_q <= WINDOW_LENGTH_RESET;
      cross_hold_q    <= CROSS_HOLD_RESET;
    end else if (cfg_valid_i) begin
      for (int i = 0; i < NUM_WEIGHTS; i++) begin
        if (cfg_index_i == REG_WEIGHT_B1 + CFG_IDX_W'(i)) begin
          weight_q[i] <= cfg_data_i;
        end
      end
      if (cfg_index_i == REG_WINDOW_LENGTH) begin
        window_length_q <= cfg_data_i[WINLEN_W-1:0];
      end
      if (cfg_index_i == REG_CROSS_HOLD) begin
        cross_hold_q <= cfg_data_i[HOLD_W-1:0];
      end
    end
  end

  // inverted reading, weight sum and set bit count
  assign d     = ~raw_sensor_i;
  assign front = |(d & FRONT_MASK);

  always_comb begin
    sum = '0;
    cnt = '0;
    for (int i = 0; i < SENSOR_W; i++) begin
      cnt = cnt + CNT_W'(d[i]);
    end
    for (int i = 0; i < NUM_WEIGHTS; i++) begin
      if (d[i+1]) begin
        sum = sum + weight_q[i];
      end
    end
  end

  // junction window decision
  always_comb begin
    road_type_e        rt_sel;
    logic [HOLD_W-1:0] hc_ld;
    wc_d   = wc_q;
    acc_d  = acc_q;
    rt_d   = rt_q;
    hc_d   = hc_q;
    code_d = CODE_OFFSET;
    mean_d = 1'b1;
    rt_sel = rt_q;
    hc_ld  = (hc_q == '0) ? cross_hold_q : hc_q;
    if (rt_q == RT_STRAIGHT) begin
      rt_sel = road_type_e'({acc_q[7:6] == SIDE_PAIR, front, acc_q[1:0] == SIDE_PAIR});
    end
    if (wc_q != '0) begin
      if (wc_q == WINLEN_W'(1)) begin
        rt_d = rt_sel;
        case (rt_sel)
          RT_UNKNOWN: begin
            rt_d   = RT_STRAIGHT;
            wc_d   = '0;
            mean_d = 1'b0;
          end
          RT_CROSS: begin
            if (hc_ld >= HOLD_W'(2)) begin
              hc_d   = hc_ld - 1'b1;
              code_d = CODE_CROSS;
            end else if (front) begin
              rt_d = RT_STRAIGHT;
              wc_d = '0;
              hc_d = '0;
            end else begin
              hc_d   = hc_ld;
              code_d = CODE_CROSS;
            end
          end
          RT_TBOTH, RT_LEFT, RT_RIGHT: begin
            if (front) begin
              rt_d = RT_STRAIGHT;
              wc_d = '0;
            end else if (rt_sel == RT_TBOTH) begin
              code_d = CODE_TBOTH;
            end else if (rt_sel == RT_LEFT) begin
              code_d = CODE_LEFT;
            end else begin
              code_d = CODE_RIGHT;
            end
          end
          RT_TLEFT: begin
            rt_d   = RT_STRAIGHT;
            wc_d   = '0;
            code_d = CODE_TLEFT;
          end
          RT_TRIGHT: begin
            rt_d   = RT_STRAIGHT;
            wc_d   = '0;
            code_d = CODE_TRIGHT;
          end
          default: begin
            wc_d = '0;
          end
        endcase
      end else begin
        acc_d = acc_q | d;
        wc_d  = wc_q - 1'b1;
      end
    end else if (|(d & EDGE_MASK)) begin
      wc_d  = window_length_q;
      acc_d = '0;
    end
    if (code_d != CODE_OFFSET || cnt == '0) begin
      mean_d = 1'b0;
    end
  end

  // tracker state, updated when a reading is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q  <= '0;
      acc_q <= '0;
      rt_q  <= RT_STRAIGHT;
      hc_q  <= '0;
    end else if (cmd_i.load) begin
      wc_q  <= wc_d;
      acc_q <= acc_d;
      rt_q  <= rt_d;
      hc_q  <= hc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      code_q <= code_d;
      mean_q <= mean_d;
    end
  end

  // serial divide of the sum by the count
  lsjt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.load),
    .step_i     (cmd_i.step),
    .dividend_i (sum),
    .divisor_i  (cnt),
    .quotient_o (quotient)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_code_q   <= code_q;
      out_offset_q <= mean_q ? quotient : '0;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign road_code_o       = out_code_q;
  assign line_offset_o     = out_offset_q;

endmodule

FILE: hw/rtl/line_sensor_junction_tracker.sv
// ----------------------------------------------------------------------------
// line_sensor_junction_tracker
// Line offset and junction classification from active-low sensor bytes.
// ----------------------------------------------------------------------------
// Each reading gives exactly one result. A reading is taken when the block is
// idle, the weighted sum is divided by the set bit count in a restoring divider
// that resolves two quotient bits per cycle, and the result then moves into the
// output register once that register is free. A new reading is taken only after
// the result has moved out of the divider. The next reading is taken while a
// result still waits in the output register. Configuration writes are taken
// in every cycle and must only be issued while the block is idle.
module line_sensor_junction_tracker
  import lsjt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  lsjt_in_if.sink     in_i,
  lsjt_out_if.source  out_o,
  lsjt_cfg_if.sink    cfg_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer
  lsjt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  lsjt_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .raw_sensor_i  (in_i.raw_sensor),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_ready_o   (cfg_i.ready),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .road_code_o   (out_o.road_code),
    .line_offset_o (out_o.line_offset)
  );

endmodule
